/* hdl/wfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Phase codes, result kinds, field widths and the result record shared by the
// parser core and the top level.
// ----------------------------------------------------------------------------
package wfd_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int OPCODE_W = 4;
  localparam int LEN_W    = 64;
  localparam int KEY_W    = 32;
  localparam int PHASE_W  = 3;
  localparam int HBC_W    = 3;
  localparam int IDX_W    = 2;

  // Packed result data: fin, opcode, masked, length, data byte, zero pad
  localparam int OUT_PACK_W = 1 + OPCODE_W + 1 + LEN_W + BYTE_W;
  localparam int OUT_DATA_W = ((OUT_PACK_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_PACK_W;

  // Parser phases
  localparam logic [PHASE_W-1:0] PH_FIRST   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEN     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_MASK    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

  // Short-length escape codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended-length and mask byte counts, minus one
  localparam logic [HBC_W-1:0] HBC_EXT16 = 3'd1;
  localparam logic [HBC_W-1:0] HBC_EXT64 = 3'd7;
  localparam logic [HBC_W-1:0] HBC_MASK  = 3'd3;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // One result item
  typedef struct packed {
    logic                valid;
    logic                kind;
    logic                fin;
    logic [OPCODE_W-1:0] opcode;
    logic                masked;
    logic [LEN_W-1:0]    payload_length;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
  } res_t;

endpackage

/* hdl/wfd_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser core
// Holds the frame state and, for each stepped byte, works out the next state
// and the result item (if any) in one pass of combinational logic.
// ----------------------------------------------------------------------------
module wfd_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [wfd_pkg::BYTE_W-1:0]  rx_byte,
  output wfd_pkg::res_t               res
);

  logic [wfd_pkg::PHASE_W-1:0]  phase_r,   phase_nxt;
  logic                         fin_r,     fin_nxt;
  logic [wfd_pkg::OPCODE_W-1:0] opcode_r,  opcode_nxt;
  logic                         mask_r,    mask_nxt;
  logic [wfd_pkg::HBC_W-1:0]    hbc_r,     hbc_nxt;
  logic [wfd_pkg::LEN_W-1:0]    len_r,     len_nxt;
  logic [wfd_pkg::KEY_W-1:0]    key_r,     key_nxt;
  logic [wfd_pkg::LEN_W-1:0]    rem_r,     rem_nxt;
  logic [wfd_pkg::IDX_W-1:0]    idx_r,     idx_nxt;

  logic                         len_done;
  logic                         hdr_done;
  logic                         fin_byte;
  logic [wfd_pkg::BYTE_W-1:0]   key_byte;
  logic [6:0]                   short_len;

  // Mask key byte for this payload position, first wire byte in the top bits
  assign key_byte  = mask_r ? key_r[{~idx_r, 3'b000} +: wfd_pkg::BYTE_W] : '0;
  assign fin_byte  = (rem_r[wfd_pkg::LEN_W-1:1] == '0);
  assign short_len = rx_byte[6:0];

  // Next state and result
  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    hbc_nxt    = hbc_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    res.valid     = 1'b0;
    res.kind      = wfd_pkg::KIND_HEADER;
    res.data_byte = '0;
    res.last      = 1'b0;

    case (phase_r)
      wfd_pkg::PH_LEN: begin
        mask_nxt = rx_byte[7];
        len_nxt  = '0;
        if (short_len == wfd_pkg::LEN_EXT16) begin
          hbc_nxt   = wfd_pkg::HBC_EXT16;
          phase_nxt = wfd_pkg::PH_EXTLEN;
        end else if (short_len == wfd_pkg::LEN_EXT64) begin
          hbc_nxt   = wfd_pkg::HBC_EXT64;
          phase_nxt = wfd_pkg::PH_EXTLEN;
        end else begin
          len_nxt  = {{(wfd_pkg::LEN_W-7){1'b0}}, short_len};
          len_done = 1'b1;
        end
      end
      wfd_pkg::PH_EXTLEN: begin
        // Extended length arrives most significant byte first
        len_nxt = {len_r[wfd_pkg::LEN_W-wfd_pkg::BYTE_W-1:0], rx_byte};
        if (hbc_r == '0) begin
          len_done = 1'b1;
        end else begin
          hbc_nxt = hbc_r - 1'b1;
        end
      end
      wfd_pkg::PH_MASK: begin
        key_nxt = {key_r[wfd_pkg::KEY_W-wfd_pkg::BYTE_W-1:0], rx_byte};
        if (hbc_r == '0) begin
          hdr_done = 1'b1;
        end else begin
          hbc_nxt = hbc_r - 1'b1;
        end
      end
      wfd_pkg::PH_PAYLOAD: begin
        res.valid     = 1'b1;
        res.kind      = wfd_pkg::KIND_DATA;
        res.data_byte = rx_byte ^ key_byte;
        res.last      = fin_byte;
        idx_nxt       = idx_r + 1'b1;
        if (fin_byte) begin
          rem_nxt   = '0;
          phase_nxt = wfd_pkg::PH_FIRST;
        end else begin
          rem_nxt = rem_r - 1'b1;
        end
      end
      default: begin
        // First header byte; unused phase codes land here too
        fin_nxt    = rx_byte[7];
        opcode_nxt = rx_byte[wfd_pkg::OPCODE_W-1:0];
        phase_nxt  = wfd_pkg::PH_LEN;
      end
    endcase

    // Length complete: collect a mask key or finish the header
    if (len_done) begin
      key_nxt = '0;
      if (mask_nxt) begin
        hbc_nxt   = wfd_pkg::HBC_MASK;
        phase_nxt = wfd_pkg::PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: emit the header item, start payload or next frame
    if (hdr_done) begin
      res.valid = 1'b1;
      res.kind  = wfd_pkg::KIND_HEADER;
      res.last  = (len_nxt == '0);
      if (len_nxt == '0) begin
        phase_nxt = wfd_pkg::PH_FIRST;
      end else begin
        rem_nxt   = len_nxt;
        idx_nxt   = '0;
        phase_nxt = wfd_pkg::PH_PAYLOAD;
      end
    end

    res.fin            = fin_nxt;
    res.opcode         = opcode_nxt;
    res.masked         = mask_nxt;
    res.payload_length = len_nxt;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wfd_pkg::PH_FIRST;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      hbc_r    <= '0;
      len_r    <= '0;
      key_r    <= '0;
      rem_r    <= '0;
      idx_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      hbc_r    <= hbc_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      rem_r    <= rem_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

/* hdl/websocket_frame_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received byte stream into header items and unmasked payload items.
//
//   Channel | Direction | tdata                                   | tuser | tlast
//   in_     | in        | [7:0] rx_byte                           | -     | -
//   out_    | out       | fin, opcode, masked, length, data, pad | kind  | last
//
// One byte is taken per cycle unless a stalled result holds the input back;
// each item passes through the input register and then the result register.
// The pace is set by the single-pass parser step between the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the first header byte. A stalled result holds in the result
// register; input is still taken while the result is being drained.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input item
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // Result item
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] fin, [4:1] opcode, [5] masked, [69:6] payload_length,
  // [77:70] data_byte, [79:78] zero
  output logic [wfd_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,  // [0] kind
  output logic                             out_tlast   // last
);

  logic                        s1_valid_r;
  logic [wfd_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                        advance;
  wfd_pkg::res_t               res;

  logic                        out_valid_r;
  logic [wfd_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                        out_user_r;
  logic                        out_last_r;

  // Step the parser when the result register can take its outcome
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  wfd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_data_r <= {{wfd_pkg::OUT_PAD_W{1'b0}}, res.data_byte, res.payload_length,
                     res.masked, res.opcode, res.fin};
      out_user_r <= res.kind;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* hdl/wfd_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer checker
// Watches the top-level ports for result framing and handshake slips.
// ----------------------------------------------------------------------------
module wfd_chk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [wfd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             out_tuser,
  input  logic                             out_tlast
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // No result straight after reset
  assert property (@(posedge clk) rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result shown after reset");

  // Header item is last exactly when the frame is empty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wfd_pkg::KIND_HEADER) |->
      (out_tlast == (out_tdata[69:6] == '0)))
    else $error("header last flag disagrees with length");

  // Header item carries a zero data byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wfd_pkg::KIND_HEADER) |-> (out_tdata[77:70] == '0))
    else $error("header item with data byte");

  // Data item that is not last belongs to a frame longer than one byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wfd_pkg::KIND_DATA) && !out_tlast |->
      (out_tdata[69:7] != '0))
    else $error("data item continues past a short frame");

endmodule

bind websocket_frame_deframer_top wfd_chk u_wfd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds well-formed frames with random headers, lengths, masks and payloads
// into the deframer byte by byte, with random gaps on the input side and
// random back-pressure on the result side. A scoreboard parses the same byte
// stream on its own and compares every header and payload item that the
// deframer emits, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 8;
  localparam int RANDOM_BYTES = 850;
  localparam int MAX_GAP     = 13;
  localparam int MAX_REPORTS = 10;

  typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  // One result item as it appears on the result port
  typedef struct packed {
    logic                          kind;
    logic                          fin;
    logic [wfd_pkg::OPCODE_W-1:0]  opcode;
    logic                          masked;
    logic [wfd_pkg::LEN_W-1:0]     length;
    logic [wfd_pkg::BYTE_W-1:0]    data;
    logic [wfd_pkg::OUT_PAD_W-1:0] pad;
    logic                          last;
  } frame_item_t;

  // Frame parser mirror and store of awaited result items
  class deframe_scoreboard;
    logic [wfd_pkg::PHASE_W-1:0]  phase     = wfd_pkg::PH_FIRST;
    logic                         fin_bit   = 1'b0;
    logic [wfd_pkg::OPCODE_W-1:0] opcode    = '0;
    logic                         mask_bit  = 1'b0;
    logic [wfd_pkg::HBC_W-1:0]    bytes_due = '0;
    logic [wfd_pkg::LEN_W-1:0]    length    = '0;
    logic [wfd_pkg::KEY_W-1:0]    key       = '0;
    logic [wfd_pkg::LEN_W-1:0]    remaining = '0;
    logic [wfd_pkg::IDX_W-1:0]    key_idx   = '0;
    frame_item_t                  awaited[$];
    int                           mismatches = 0;

    function int pending();
      return awaited.size();
    endfunction

    function void queue_item(logic kind, logic [wfd_pkg::BYTE_W-1:0] data, logic last);
      frame_item_t it;
      it.kind   = kind;
      it.fin    = fin_bit;
      it.opcode = opcode;
      it.masked = mask_bit;
      it.length = length;
      it.data   = data;
      it.pad    = '0;
      it.last   = last;
      awaited.push_back(it);
    endfunction

    // Emit the header item; an empty frame closes here
    function void close_header();
      logic empty;
      empty = (length == '0);
      queue_item(wfd_pkg::KIND_HEADER, '0, empty);
      if (empty) begin
        phase = wfd_pkg::PH_FIRST;
      end else begin
        remaining = length;
        key_idx   = '0;
        phase     = wfd_pkg::PH_PAYLOAD;
      end
    endfunction

    // Length known: collect the mask key or finish the header
    function void close_length();
      key = '0;
      if (mask_bit) begin
        bytes_due = wfd_pkg::HBC_MASK;
        phase     = wfd_pkg::PH_MASK;
      end else begin
        close_header();
      end
    endfunction

    // Advance the parser by one accepted byte
    function void note_input(logic [wfd_pkg::BYTE_W-1:0] b);
      logic [wfd_pkg::BYTE_W-1:0] k;
      logic                       closing;
      case (phase)
        wfd_pkg::PH_LEN: begin
          mask_bit = b[7];
          length   = '0;
          if (b[6:0] == wfd_pkg::LEN_EXT16) begin
            bytes_due = wfd_pkg::HBC_EXT16;
            phase     = wfd_pkg::PH_EXTLEN;
          end else if (b[6:0] == wfd_pkg::LEN_EXT64) begin
            bytes_due = wfd_pkg::HBC_EXT64;
            phase     = wfd_pkg::PH_EXTLEN;
          end else begin
            length = wfd_pkg::LEN_W'(b[6:0]);
            close_length();
          end
        end
        wfd_pkg::PH_EXTLEN: begin
          length = {length[wfd_pkg::LEN_W-9:0], b};
          if (bytes_due == '0) close_length();
          else bytes_due = bytes_due - 1'b1;
        end
        wfd_pkg::PH_MASK: begin
          key = {key[wfd_pkg::KEY_W-9:0], b};
          if (bytes_due == '0) close_header();
          else bytes_due = bytes_due - 1'b1;
        end
        wfd_pkg::PH_PAYLOAD: begin
          k       = mask_bit ? key[8 * (3 - int'(key_idx)) +: 8] : '0;
          closing = (remaining <= 1);
          queue_item(wfd_pkg::KIND_DATA, b ^ k, closing);
          key_idx = key_idx + 1'b1;
          if (closing) begin
            remaining = '0;
            phase     = wfd_pkg::PH_FIRST;
          end else begin
            remaining = remaining - 1'b1;
          end
        end
        default: begin
          fin_bit = b[7];
          opcode  = b[3:0];
          phase   = wfd_pkg::PH_LEN;
        end
      endcase
    endfunction

    // Compare one accepted result item with the oldest awaited one
    function void check_result(logic [wfd_pkg::OUT_DATA_W-1:0] tdata, logic tuser,
                               logic tlast);
      frame_item_t want;
      frame_item_t got;
      got.kind   = tuser;
      got.fin    = tdata[0];
      got.opcode = tdata[4:1];
      got.masked = tdata[5];
      got.length = tdata[69:6];
      got.data   = tdata[77:70];
      got.pad    = tdata[79:78];
      got.last   = tlast;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected item kind=%0b fin=%0b op=%h m=%0b len=%h data=%h last=%0b",
                   $realtime, got.kind, got.fin, got.opcode, got.masked, got.length,
                   got.data, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: item mismatch", $realtime);
          $display("  expected kind=%0b fin=%0b op=%h m=%0b len=%h data=%h pad=%0h last=%0b",
                   want.kind, want.fin, want.opcode, want.masked, want.length,
                   want.data, want.pad, want.last);
          $display("  actual   kind=%0b fin=%0b op=%h m=%0b len=%h data=%h pad=%0h last=%0b",
                   got.kind, got.fin, got.opcode, got.masked, got.length,
                   got.data, got.pad, got.last);
        end
      end
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [wfd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;

  deframe_scoreboard sb = new();
  int  bytes_sent  = 0;
  int  idle_cycles = 0;
  bit  in_quiet    = 1'b0;
  bit  out_quiet   = 1'b0;

  websocket_frame_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Present one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b);
    bytes_sent++;
  endtask

  // Send a whole frame header followed by n_payload random payload bytes
  task automatic send_frame(input logic [7:0] lead, input len_form_t form,
                            input logic [63:0] len, input logic masked,
                            input logic [31:0] mkey, input int n_payload);
    send_byte(lead);
    case (form)
      FORM_EXT16: begin
        send_byte({masked, wfd_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, wfd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
      default: begin
        send_byte({masked, len[6:0]});
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(mkey[8 * i +: 8]);
    repeat (n_payload) send_byte(8'($urandom));
  endtask

  // Drain results with random back-pressure and occasional full-rate stretches
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      gap = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Stop the run when neither side has moved an item for too long
  initial begin
    do begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end while (idle_cycles < IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Main stimulus
  initial begin
    logic [7:0]  lead;
    logic        masked;
    logic [31:0] mkey;
    logic [63:0] len;
    len_form_t   form;
    int          pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty frame with reserved bits and the top opcode set
    send_frame(8'hFF, FORM_SHORT, 64'd0, 1'b0, 32'h0, 0);
    // Empty masked frame, all-ones key
    send_frame(8'h00, FORM_SHORT, 64'd0, 1'b1, 32'hFFFF_FFFF, 0);
    // Empty frame with a 16-bit extended length
    send_frame(8'h89, FORM_EXT16, 64'd0, 1'b0, 32'h0, 0);
    // Non-minimal 64-bit length carrying one unmasked byte
    send_frame(8'h72, FORM_EXT64, 64'd1, 1'b0, 32'h0, 1);

    // Random frames, mostly short
    while (bytes_sent < RANDOM_BYTES) begin
      in_quiet = ($urandom_range(0, 4) == 0);
      lead     = 8'($urandom);
      masked   = 1'($urandom);
      mkey     = $urandom;
      pick     = $urandom_range(0, 15);
      if (pick < 10) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(0, 12));
      end else if (pick < 11) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(100, 125));
      end else if (pick < 13) begin
        form = FORM_EXT16;
        len  = 64'($urandom_range(0, 40));
      end else if (pick < 14) begin
        form = FORM_EXT16;
        len  = 64'($urandom_range(126, 300));
      end else begin
        form = FORM_EXT64;
        len  = 64'($urandom_range(0, 20));
      end
      send_frame(lead, form, len, masked, mkey, int'(len));
    end

    // Length with its top bit set: the frame stays open, so it goes last
    in_quiet = 1'b0;
    send_frame(8'h81, FORM_EXT64, 64'h8000_0000_0000_0005, 1'b1, $urandom, 6);
    in_tvalid <= 1'b0;

    // Wait for every awaited item, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
